@@ rtl/core/bdpq_pkg.sv @@
// Shared constants, codes and types of the bounded double-ended priority queue.
`default_nettype none
package bdpq_pkg;
   localparam int DEPTH     = 16;
   localparam int DATA_BITS = 32;
   localparam int PRIO_W    = 16;
   localparam int CNT_W     = 5;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int ADDR_W    = 3;

   typedef enum logic [2:0] {
      ACT_ADD       = 3'd0,
      ACT_PEEK_HIGH = 3'd1,
      ACT_POP_HIGH  = 3'd2,
      ACT_PEEK_LOW  = 3'd3,
      ACT_POP_LOW   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_SHIFT  = 2'd1,
      CELL_INSERT = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type                op;
      logic signed [PRIO_W-1:0]   prio;
      logic [DATA_BITS-1:0]       data;
   } cell_ctrl_type;

   localparam logic [ADDR_W-1:0] REG_CAPACITY = 3'd0;
endpackage
`default_nettype wire

@@ rtl/core/bdpq_req_if.sv @@
// Request channel: valid/ready handshake with the queue operation fields.
`default_nettype none
interface bdpq_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] priority_req;
   logic [31:0] payload;

   modport source (output valid, output action, output priority_req, output payload,
                   input ready);
   modport sink (input valid, input action, input priority_req, input payload,
                 output ready);
endinterface
`default_nettype wire

@@ rtl/core/bdpq_rsp_if.sv @@
// Response channel: valid/ready handshake with the result fields.
`default_nettype none
interface bdpq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] out_payload;
   logic [4:0]  occupancy;
   logic        is_full;
   logic        is_empty;

   modport source (output valid, output status, output out_payload, output occupancy,
                   output is_full, output is_empty, input ready);
   modport sink (input valid, input status, input out_payload, input occupancy,
                 input is_full, input is_empty, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bounded_double_ended_priority_queue_core.sv @@
// Top level of the bounded double-ended priority queue.
// Usage:
//   req_chan carries one operation per transaction: add, peek or pop at the
//   high or low end. rsp_chan returns one transaction per request with status,
//   payload read, occupancy and full/empty flags. The csr_ port writes the
//   capacity register (address 0); pready is always high.
// Operation:
//   Entries sit sorted in a chain of cells, lowest at cell 0. Every cell
//   compares against the new priority in the same cycle. An add into a queue
//   already at or above capacity first evicts from the low end, shifting the
//   chain down once per evicted entry. One request is handled at a time; a new
//   request is accepted while the previous result still waits.
// Reset:
//   Synchronous, active high. The queue empties and capacity returns to 16.
// Stall:
//   While rsp_chan is stalled the finished result holds; a request taken in
//   the meantime holds in its work cycle until the result register frees.
`default_nettype none
module bounded_double_ended_priority_queue_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bdpq_req_if.sink                           req_chan,
   bdpq_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [bdpq_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import bdpq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WORK = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   action_type              action_ff, action_in;
   logic signed [PRIO_W-1:0] prio_ff, prio_in;
   logic [DATA_BITS-1:0]    data_ff, data_in;
   status_type              status_ff, status_in;
   logic [31:0]             out_data_ff, out_data_in;
   logic [CNT_W-1:0]        occ_ff, occ_in;
   logic                    full_ff, full_in;
   logic                    empty_ff, empty_in;

   logic [CNT_W-1:0]        capacity;
   logic [CNT_W-1:0]        cap_eff;
   logic [CNT_W-1:0]        count_m1;
   logic                    evict;
   logic                    finish;
   logic                    accept;
   cell_ctrl_type           ctrl;

   logic signed [PRIO_W-1:0] cell_prio [DEPTH];
   logic [DATA_BITS-1:0]     cell_data [DEPTH];
   logic [DEPTH-1:0]         cell_lt;

   bdpq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     below_lt;
      logic signed [PRIO_W-1:0] below_prio;
      logic [DATA_BITS-1:0]     below_data;
      logic signed [PRIO_W-1:0] above_prio;
      logic [DATA_BITS-1:0]     above_data;
      logic                     valid;

      if (i == 0) begin : g_bottom
         assign below_lt   = 1'b1;
         assign below_prio = '0;
         assign below_data = '0;
      end else begin : g_mid_below
         assign below_lt   = cell_lt[i-1];
         assign below_prio = cell_prio[i-1];
         assign below_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_top
         assign above_prio = '0;
         assign above_data = '0;
      end else begin : g_mid_above
         assign above_prio = cell_prio[i+1];
         assign above_data = cell_data[i+1];
      end
      assign valid = (CNT_W'(i) < count_ff);

      bdpq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .valid      (valid),
         .below_lt   (below_lt),
         .below_prio (below_prio),
         .below_data (below_data),
         .above_prio (above_prio),
         .above_data (above_data),
         .lt         (cell_lt[i]),
         .prio       (cell_prio[i]),
         .data       (cell_data[i])
      );
   end

   assign cap_eff  = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
   assign count_m1 = count_ff - 1'b1;
   assign evict    = (state_ff == ST_WORK) && (action_ff == ACT_ADD) &&
                     (cap_eff != '0) && (count_ff >= cap_eff);
   assign finish   = (state_ff == ST_WORK) && !evict && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept   = req_chan.valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      action_in    = action_ff;
      prio_in      = prio_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      out_data_in  = out_data_ff;
      occ_in       = occ_ff;
      full_in      = full_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ctrl.op      = CELL_HOLD;
      ctrl.prio    = prio_ff;
      ctrl.data    = data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               action_in = action_type'(req_chan.action);
               prio_in   = req_chan.priority_req;
               data_in   = DATA_BITS'(req_chan.payload);
               state_in  = ST_WORK;
            end
         end
         ST_WORK: begin
            if (evict) begin
               ctrl.op  = CELL_SHIFT;
               count_in = count_m1;
            end else if (finish) begin
               status_in   = STATUS_OK;
               out_data_in = '0;
               case (action_ff) inside
                  ACT_ADD: begin
                     if (cap_eff == '0) begin
                        status_in = STATUS_REJECTED;
                     end else begin
                        ctrl.op  = CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_PEEK_HIGH, ACT_POP_HIGH: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        out_data_in = 32'(cell_data[count_m1[IDX_W-1:0]]);
                        if (action_ff == ACT_POP_HIGH) begin
                           count_in = count_m1;
                        end
                     end
                  end
                  ACT_PEEK_LOW, ACT_POP_LOW: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        out_data_in = 32'(cell_data[0]);
                        if (action_ff == ACT_POP_LOW) begin
                           ctrl.op  = CELL_SHIFT;
                           count_in = count_m1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               occ_in       = count_in;
               full_in      = (count_in >= cap_eff);
               empty_in     = (count_in == '0);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      prio_ff     <= prio_in;
      data_ff     <= data_in;
      status_ff   <= status_in;
      out_data_ff <= out_data_in;
      occ_ff      <= occ_in;
      full_ff     <= full_in;
      empty_ff    <= empty_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.out_payload = out_data_ff;
   assign rsp_chan.occupancy   = occ_ff;
   assign rsp_chan.is_full     = full_ff;
   assign rsp_chan.is_empty    = empty_ff;
endmodule
`default_nettype wire

@@ rtl/core/bdpq_cell.sv @@
// One slot of the sorted shift chain: holds an entry, shifts down or opens a gap on insert.
`default_nettype none
module bdpq_cell (
   input  wire logic                                clock,
   input  wire bdpq_pkg::cell_ctrl_type             ctrl,
   input  wire logic                                valid,
   input  wire logic                                below_lt,
   input  wire logic signed [bdpq_pkg::PRIO_W-1:0]  below_prio,
   input  wire logic [bdpq_pkg::DATA_BITS-1:0]      below_data,
   input  wire logic signed [bdpq_pkg::PRIO_W-1:0]  above_prio,
   input  wire logic [bdpq_pkg::DATA_BITS-1:0]      above_data,
   output logic                                     lt,
   output logic signed [bdpq_pkg::PRIO_W-1:0]       prio,
   output logic [bdpq_pkg::DATA_BITS-1:0]           data
);
   import bdpq_pkg::*;

   logic signed [PRIO_W-1:0] prio_ff, prio_in;
   logic [DATA_BITS-1:0]     data_ff, data_in;

   assign lt   = valid && (prio_ff < ctrl.prio);
   assign prio = prio_ff;
   assign data = data_ff;

   always_comb begin
      prio_in = prio_ff;
      data_in = data_ff;
      case (ctrl.op)
         CELL_SHIFT: begin
            prio_in = above_prio;
            data_in = above_data;
         end
         CELL_INSERT: begin
            if (!lt && below_lt) begin
               prio_in = ctrl.prio;
               data_in = ctrl.data;
            end else if (!lt) begin
               prio_in = below_prio;
               data_in = below_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      data_ff <= data_in;
   end
endmodule
`default_nettype wire

@@ rtl/core/bdpq_csr.sv @@
// APB-style register port holding the capacity register.
`default_nettype none
module bdpq_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [bdpq_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output logic [bdpq_pkg::CNT_W-1:0]         capacity
);
   import bdpq_pkg::*;

   logic [CNT_W-1:0] capacity_ff, capacity_in;
   logic             hit;

   assign hit        = (csr_paddr[2] == REG_CAPACITY[2]);
   assign csr_pready = 1'b1;
   assign capacity   = capacity_ff;
   assign csr_prdata = hit ? {{(32-CNT_W){1'b0}}, capacity_ff} : 32'd0;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         capacity_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CNT_W'(DEPTH);
      end else begin
         capacity_ff <= capacity_in;
      end
   end
endmodule
`default_nettype wire

@@ dv/bounded_double_ended_priority_queue_core_tb.sv @@
// Testbench for the bounded double-ended priority queue: directed table, random traffic, scoreboard.
module bounded_double_ended_priority_queue_core_tb;
   import bdpq_pkg::*;

   localparam logic [2:0] ACT_NOP_A = 3'd5;
   localparam logic [2:0] ACT_NOP_B = 3'd6;
   localparam logic [2:0] ACT_NOP_C = 3'd7;

   localparam int DIRECTED_ROWS   = 26;
   localparam int ITEMS_PER_PHASE = 186;
   localparam int HOLD_CYCLES     = 80;
   localparam int HOLD_AT_FIRST   = 300;
   localparam int HOLD_AT_SECOND  = 1100;

   localparam logic [4:0] CAPACITY_STEPS [9] =
      '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd2, 5'd16};

   typedef struct packed {
      status_type  status;
      logic [31:0] payload;
      logic [4:0]  occupancy;
      logic        full;
      logic        empty;
   } outcome_type;

   typedef struct {
      logic signed [15:0] prio;
      logic [31:0]        data;
   } held_entry_type;

   typedef enum bit {ROW_ITEM, ROW_CAPACITY} plan_kind_type;

   typedef struct {
      plan_kind_type      kind;
      logic [2:0]         action;
      logic signed [15:0] prio;
      logic [31:0]        payload;
      logic [4:0]         capacity;
      bit                 checked;
      outcome_type        want;
   } plan_row_type;

   localparam outcome_type NO_OUTCOME    = '{STATUS_OK, 32'h0, 5'd0, 1'b0, 1'b0};
   localparam outcome_type QUEUE_DRAINED = '{STATUS_EMPTY, 32'h0, 5'd0, 1'b0, 1'b1};
   localparam outcome_type NOP_ON_EMPTY  = '{STATUS_OK, 32'h0, 5'd0, 1'b0, 1'b1};

   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      '{ROW_ITEM,     ACT_PEEK_HIGH, 16'sd0,     32'h0,         5'd0,  1'b1, QUEUE_DRAINED},
      '{ROW_ITEM,     ACT_POP_LOW,   16'sd0,     32'h0,         5'd0,  1'b1, QUEUE_DRAINED},
      '{ROW_ITEM,     ACT_NOP_A,     16'sh7FFF,  32'hFFFF_FFFF, 5'd0,  1'b1, NOP_ON_EMPTY},
      '{ROW_ITEM,     ACT_NOP_C,     16'sh8000,  32'hFFFF_FFFF, 5'd0,  1'b1, NOP_ON_EMPTY},
      '{ROW_CAPACITY, ACT_ADD,       16'sd0,     32'h0,         5'd16, 1'b0, NO_OUTCOME},
      '{ROW_ITEM,     ACT_ADD,       16'sh7FFF,  32'hFFFF_FFFF, 5'd0,  1'b1,
        '{STATUS_OK, 32'h0, 5'd1, 1'b0, 1'b0}},
      '{ROW_ITEM,     ACT_ADD,       16'sh8000,  32'h0,         5'd0,  1'b1,
        '{STATUS_OK, 32'h0, 5'd2, 1'b0, 1'b0}},
      '{ROW_ITEM,     ACT_ADD,       16'sd0,     32'hA5A5_A5A5, 5'd0,  1'b0, NO_OUTCOME},
      '{ROW_ITEM,     ACT_ADD,       16'sd0,     32'h5A5A_5A5A, 5'd0,  1'b0, NO_OUTCOME},
      '{ROW_ITEM,     ACT_PEEK_HIGH, 16'sd0,     32'h0,         5'd0,  1'b1,
        '{STATUS_OK, 32'hFFFF_FFFF, 5'd4, 1'b0, 1'b0}},
      '{ROW_ITEM,     ACT_PEEK_LOW,  16'sd0,     32'h0,         5'd0,  1'b1,
        '{STATUS_OK, 32'h0, 5'd4, 1'b0, 1'b0}},
      '{ROW_ITEM,     ACT_POP_HIGH,  16'sd0,     32'h0,         5'd0,  1'b1,
        '{STATUS_OK, 32'hFFFF_FFFF, 5'd3, 1'b0, 1'b0}},
      '{ROW_ITEM,     ACT_POP_LOW,   16'sd0,     32'h0,         5'd0,  1'b1,
        '{STATUS_OK, 32'h0, 5'd2, 1'b0, 1'b0}},
      '{ROW_ITEM,     ACT_POP_HIGH,  16'sd0,     32'h0,         5'd0,  1'b0, NO_OUTCOME},
      '{ROW_ITEM,     ACT_NOP_B,     16'sd0,     32'h1234_5678, 5'd0,  1'b0, NO_OUTCOME},
      '{ROW_CAPACITY, ACT_ADD,       16'sd0,     32'h0,         5'd0,  1'b0, NO_OUTCOME},
      '{ROW_ITEM,     ACT_ADD,       16'sd100,   32'h0000_1234, 5'd0,  1'b1,
        '{STATUS_REJECTED, 32'h0, 5'd1, 1'b1, 1'b0}},
      '{ROW_ITEM,     ACT_PEEK_LOW,  16'sd0,     32'h0,         5'd0,  1'b0, NO_OUTCOME},
      '{ROW_CAPACITY, ACT_ADD,       16'sd0,     32'h0,         5'd31, 1'b0, NO_OUTCOME},
      '{ROW_ITEM,     ACT_ADD,       16'sd1,     32'h0000_0001, 5'd0,  1'b0, NO_OUTCOME},
      '{ROW_ITEM,     ACT_ADD,       -16'sd1,    32'h8000_0000, 5'd0,  1'b0, NO_OUTCOME},
      '{ROW_CAPACITY, ACT_ADD,       16'sd0,     32'h0,         5'd1,  1'b0, NO_OUTCOME},
      '{ROW_ITEM,     ACT_PEEK_HIGH, 16'sd0,     32'h0,         5'd0,  1'b0, NO_OUTCOME},
      '{ROW_ITEM,     ACT_ADD,       16'sd5,     32'hDEAD_BEEF, 5'd0,  1'b0, NO_OUTCOME},
      '{ROW_ITEM,     ACT_POP_LOW,   16'sd0,     32'h0,         5'd0,  1'b0, NO_OUTCOME},
      '{ROW_ITEM,     ACT_POP_HIGH,  16'sd0,     32'h0,         5'd0,  1'b1, QUEUE_DRAINED}
   };

   logic clock = 1'b0;
   logic reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   bdpq_req_if req_chan ();
   bdpq_rsp_if rsp_chan ();

   bounded_double_ended_priority_queue_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   held_entry_type ranked_entries [$];
   outcome_type    due_outcomes [$];
   logic [4:0]     capacity_setting = 5'd16;

   int error_count     = 0;
   int ops_sent        = 0;
   int results_seen    = 0;
   int adds_seen       = 0;
   int evictions       = 0;
   int rejected_adds   = 0;
   int empty_reads     = 0;
   int input_stalls    = 0;
   int capacity_writes = 0;

   function automatic outcome_type serve_operation(input logic [2:0] op,
                                                   input logic signed [15:0] prio,
                                                   input logic [31:0] data);
      outcome_type    res;
      int             limit;
      int             pos;
      held_entry_type slot;
      res = NO_OUTCOME;
      limit = (capacity_setting > DEPTH) ? DEPTH : int'(capacity_setting);
      if (op == ACT_ADD) begin
         adds_seen++;
         if (limit == 0) begin
            res.status = STATUS_REJECTED;
            rejected_adds++;
         end else begin
            while (ranked_entries.size() >= limit && ranked_entries.size() > 0) begin
               void'(ranked_entries.pop_front());
               evictions++;
            end
            if (ranked_entries.size() < DEPTH) begin
               pos = 0;
               while (pos < ranked_entries.size() && ranked_entries[pos].prio < prio) pos++;
               slot.prio = prio;
               slot.data = data;
               ranked_entries.insert(pos, slot);
            end
         end
      end else if (op == ACT_PEEK_HIGH || op == ACT_POP_HIGH ||
                   op == ACT_PEEK_LOW || op == ACT_POP_LOW) begin
         if (ranked_entries.size() == 0) begin
            res.status = STATUS_EMPTY;
            empty_reads++;
         end else if (op == ACT_PEEK_HIGH || op == ACT_POP_HIGH) begin
            res.payload = ranked_entries[$].data;
            if (op == ACT_POP_HIGH) void'(ranked_entries.pop_back());
         end else begin
            res.payload = ranked_entries[0].data;
            if (op == ACT_POP_LOW) void'(ranked_entries.pop_front());
         end
      end
      res.occupancy = 5'(ranked_entries.size());
      res.full      = ranked_entries.size() >= limit;
      res.empty     = ranked_entries.size() == 0;
      return res;
   endfunction

   task automatic issue_op(input logic [2:0] op, input logic signed [15:0] prio,
                           input logic [31:0] data, input bit typed, input outcome_type want);
      outcome_type modeled;
      req_chan.valid        <= 1'b1;
      req_chan.action       <= op;
      req_chan.priority_req <= prio;
      req_chan.payload      <= data;
      do @(posedge clock); while (!req_chan.ready);
      modeled = serve_operation(op, prio, data);
      due_outcomes.push_back(typed ? want : modeled);
      ops_sent++;
   endtask

   task automatic idle_sender(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (due_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [4:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_CAPACITY;
      csr_pwdata  <= {27'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      capacity_setting = value;
      capacity_writes++;
   endtask

   always @(posedge clock) begin
      outcome_type seen;
      outcome_type want;
      if (!reset && req_chan.valid && !req_chan.ready) input_stalls++;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.status    = status_type'(rsp_chan.status);
         seen.payload   = rsp_chan.out_payload;
         seen.occupancy = rsp_chan.occupancy;
         seen.full      = rsp_chan.is_full;
         seen.empty     = rsp_chan.is_empty;
         results_seen++;
         if (due_outcomes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction: status %0d payload %h occupancy %0d",
                     $realtime, seen.status, seen.payload, seen.occupancy);
         end else begin
            want = due_outcomes.pop_front();
            if (seen.status !== want.status) begin
               error_count++;
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $realtime, want.status, seen.status);
            end
            if (seen.payload !== want.payload) begin
               error_count++;
               $display("%0t: out_payload mismatch: expected %h, actual %h",
                        $realtime, want.payload, seen.payload);
            end
            if (seen.occupancy !== want.occupancy) begin
               error_count++;
               $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                        $realtime, want.occupancy, seen.occupancy);
            end
            if (seen.full !== want.full) begin
               error_count++;
               $display("%0t: is_full mismatch: expected %b, actual %b",
                        $realtime, want.full, seen.full);
            end
            if (seen.empty !== want.empty) begin
               error_count++;
               $display("%0t: is_empty mismatch: expected %b, actual %b",
                        $realtime, want.empty, seen.empty);
            end
         end
      end
   end

   initial begin
      int  mode;
      int  stretch;
      int  tick;
      int  hold_left;
      int  holds_done;
      bit  take;
      rsp_chan.ready <= 1'b0;
      mode       = 0;
      stretch    = 0;
      tick       = 0;
      hold_left  = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_left > 0) begin
            take = 1'b0;
            hold_left--;
         end else if ((holds_done == 0 && results_seen >= HOLD_AT_FIRST) ||
                      (holds_done == 1 && results_seen >= HOLD_AT_SECOND)) begin
            take = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            holds_done++;
         end else begin
            if (stretch == 0) begin
               mode    = $urandom_range(0, 2);
               stretch = $urandom_range(20, 120);
            end
            stretch--;
            case (mode)
               0: take = 1'b1;
               1: take = 1'($urandom_range(0, 1));
               default: take = (tick % 3) == 0;
            endcase
         end
         rsp_chan.ready <= take;
      end
   end

   initial begin
      int                 burst;
      int                 add_share;
      int                 roll;
      int                 offset;
      int                 phase_count;
      logic [2:0]         op;
      logic signed [15:0] prio;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.action       <= ACT_ADD;
      req_chan.priority_req <= 16'd0;
      req_chan.payload      <= 32'd0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= REG_CAPACITY;
      csr_pwdata            <= 32'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CAPACITY) begin
            settle();
            write_capacity(directed_plan[i].capacity);
         end else begin
            issue_op(directed_plan[i].action, directed_plan[i].prio, directed_plan[i].payload,
                     directed_plan[i].checked, directed_plan[i].want);
         end
      end

      foreach (CAPACITY_STEPS[p]) begin
         settle();
         write_capacity(CAPACITY_STEPS[p]);
         phase_count = 0;
         while (phase_count < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
               0: add_share = 25;
               1: add_share = 55;
               default: add_share = 85;
            endcase
            repeat (burst) begin
               roll = $urandom_range(0, 99);
               if (roll < add_share) begin
                  op = ACT_ADD;
               end else if (roll >= 96) begin
                  op = ACT_NOP_A + 3'($urandom_range(0, 2));
               end else begin
                  case ($urandom_range(0, 3))
                     0: op = ACT_PEEK_HIGH;
                     1: op = ACT_POP_HIGH;
                     2: op = ACT_PEEK_LOW;
                     default: op = ACT_POP_LOW;
                  endcase
               end
               case ($urandom_range(0, 5)) inside
                  0, 1: begin
                     offset = $urandom_range(0, 8) - 4;
                     prio = offset[15:0];
                  end
                  2: prio = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                  default: prio = 16'($urandom);
               endcase
               issue_op(op, prio, $urandom, 1'b0, NO_OUTCOME);
               phase_count++;
            end
            idle_sender($urandom_range(1, 8));
         end
      end

      settle();
      repeat (20) @(posedge clock);
      $display("Ran %0d operations over %0d capacity writes: %0d adds, %0d evictions,",
               ops_sent, capacity_writes, adds_seen, evictions);
      $display("%0d rejected adds, %0d reads of an empty queue, %0d input stall cycles",
               rejected_adds, empty_reads, input_stalls);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding", due_outcomes.size());
      $display("FAILED: results differ");
      $finish;
   end
endmodule
